/* hw/rtl/kims_pkg.sv */
// Shared constants, codes and types for the kagome Ising Metropolis sweep core.
package kims_pkg;

    localparam int SIDE_DEFAULT = 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam int COORD_W    = 4;
    localparam int RND_W      = 32;
    localparam int ENERGY_W   = 12;
    localparam int MAG_W      = 10;
    localparam int THRESH_W   = 33;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 33'h1_0000_0000;

    // Register index, taken from paddr[3]
    localparam logic REG_ACCEPT_DE4 = 1'b0;
    localparam logic REG_ACCEPT_DE8 = 1'b1;

    // Item kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TRIAL = 1'b1;

    // Sublattice codes; the last one names no store
    localparam logic [1:0] SUB_ONE   = 2'd0;
    localparam logic [1:0] SUB_TWO   = 2'd1;
    localparam logic [1:0] SUB_THREE = 2'd2;
    localparam logic [1:0] SUB_NONE  = 2'd3;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_ISSUE,
        BK_EXEC
    } back_state_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic       trial;
        logic       active;
        logic [1:0] sub;
        logic       spin_up;
        logic       sweep_done;
    } kims_cmd_t;

endpackage

/* hw/rtl/kims_if.sv */
// Valid/ready channel interfaces for trial/write items and result items.
interface kims_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [kims_pkg::RND_W-1:0]   random_value;
    logic [1:0]                 sublattice;
    logic [kims_pkg::COORD_W-1:0] col;
    logic [kims_pkg::COORD_W-1:0] row;
    logic                       spin_up;

    modport source (
        output valid, action, random_value, sublattice, col, row, spin_up,
        input  ready
    );
    modport sink (
        input  valid, action, random_value, sublattice, col, row, spin_up,
        output ready
    );
endinterface

interface kims_out_if;
    logic                               valid;
    logic                               ready;
    logic                               flipped;
    logic signed [kims_pkg::ENERGY_W-1:0] energy;
    logic signed [kims_pkg::MAG_W-1:0]    mag_one;
    logic signed [kims_pkg::MAG_W-1:0]    mag_two;
    logic signed [kims_pkg::MAG_W-1:0]    mag_three;
    logic                               sweep_done;

    modport source (
        output valid, flipped, energy, mag_one, mag_two, mag_three, sweep_done,
        input  ready
    );
    modport sink (
        input  valid, flipped, energy, mag_one, mag_two, mag_three, sweep_done,
        output ready
    );
endinterface

/* hw/rtl/kims_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
module kims_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = kims_pkg::SIDE_DEFAULT * kims_pkg::SIDE_DEFAULT
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                           rdata_a,
    output logic [WIDTH-1:0]                           rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* hw/rtl/kims_front.sv */
// Front end: accepts items, walks the sweep order and forms the store addresses.
module kims_front #(
    parameter int SIDE = kims_pkg::SIDE_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    kims_in_if.sink                              items,
    input  logic                                 clearing,
    input  logic                                 push_ready,
    output logic                                 push_valid,
    output kims_pkg::kims_cmd_t                  push_cmd,
    output logic [kims_pkg::RND_W-1:0]           push_rnd,
    output logic [$clog2(SIDE * SIDE)-1:0]       push_self,
    output logic [$clog2(SIDE * SIDE)-1:0]       push_na,
    output logic [$clog2(SIDE * SIDE)-1:0]       push_nb,
    output logic [$clog2(SIDE * SIDE)-1:0]       push_nc
);

    localparam int XW = $clog2(SIDE);
    localparam int AW = $clog2(SIDE * SIDE);
    localparam logic [XW-1:0] LAST = XW'(SIDE - 1);

    logic [XW-1:0] x_reg, x_next;
    logic [XW-1:0] y_reg, y_next;
    logic [1:0]    sub_reg, sub_next;

    logic          accept;
    logic          is_trial;
    logic          wr_ok;
    logic [XW-1:0] sx, sy, xm, xp, ym, yp;
    logic [1:0]    ss;

    function automatic logic [AW-1:0] site_addr(input logic [XW-1:0] x, input logic [XW-1:0] y);
        site_addr = AW'(AW'(y) * AW'(SIDE) + AW'(x));
    endfunction

    assign items.ready = push_ready && !clearing;
    assign accept      = items.valid && items.ready;
    assign push_valid  = accept;
    assign is_trial    = (items.action == kims_pkg::ACT_TRIAL);

    assign wr_ok = (items.sublattice != kims_pkg::SUB_NONE)
                && (32'(items.col) < 32'(SIDE))
                && (32'(items.row) < 32'(SIDE));

    assign sx = is_trial ? x_reg : XW'(items.col);
    assign sy = is_trial ? y_reg : XW'(items.row);
    assign ss = is_trial ? sub_reg : items.sublattice;

    // Periodic neighbour coordinates
    assign xm = (sx == '0)   ? LAST : sx - XW'(1);
    assign xp = (sx == LAST) ? '0   : sx + XW'(1);
    assign ym = (sy == '0)   ? LAST : sy - XW'(1);
    assign yp = (sy == LAST) ? '0   : sy + XW'(1);

    // Port A of every store reads (x, y); port B reads the one shifted neighbour
    assign push_self = site_addr(sx, sy);
    assign push_na   = (ss == kims_pkg::SUB_TWO) ? site_addr(xp, sy) : site_addr(sx, yp);
    assign push_nb   = (ss == kims_pkg::SUB_ONE) ? site_addr(xm, sy) : site_addr(xm, yp);
    assign push_nc   = (ss == kims_pkg::SUB_ONE) ? site_addr(sx, ym) : site_addr(xp, ym);

    always_comb
    begin
        push_cmd.trial      = is_trial;
        push_cmd.active     = is_trial || wr_ok;
        push_cmd.sub        = ss;
        push_cmd.spin_up    = items.spin_up;
        push_cmd.sweep_done = is_trial && (sub_reg == kims_pkg::SUB_THREE)
                              && (x_reg == LAST) && (y_reg == LAST);
    end

    assign push_rnd = items.random_value;

    // Advance the sweep pointer on every accepted trial
    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        sub_next = sub_reg;
        if (accept && is_trial)
        begin
            if (x_reg == LAST)
            begin
                x_next = '0;
                if (y_reg == LAST)
                begin
                    y_next   = '0;
                    sub_next = (sub_reg == kims_pkg::SUB_THREE) ? kims_pkg::SUB_ONE
                                                                : sub_reg + 2'd1;
                end
                else
                begin
                    y_next = y_reg + XW'(1);
                end
            end
            else
            begin
                x_next = x_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            y_reg   <= '0;
            sub_reg <= kims_pkg::SUB_ONE;
        end
        else
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            sub_reg <= sub_next;
        end
    end

endmodule

/* hw/rtl/kims_fifo.sv */
// Short register queue between front and back.
module kims_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = kims_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/kims_back.sv */
// Back end: spin stores, clearing pass, Metropolis decision, counters, result register.
module kims_back #(
    parameter int SIDE = kims_pkg::SIDE_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [kims_pkg::THRESH_W-1:0]        thr_de4,
    input  logic [kims_pkg::THRESH_W-1:0]        thr_de8,
    output logic                                 clearing,
    input  logic                                 cmd_valid,
    output logic                                 cmd_pop,
    input  kims_pkg::kims_cmd_t                  cmd_in,
    input  logic [kims_pkg::RND_W-1:0]           rnd_in,
    input  logic [$clog2(SIDE * SIDE)-1:0]       self_in,
    input  logic [$clog2(SIDE * SIDE)-1:0]       na_in,
    input  logic [$clog2(SIDE * SIDE)-1:0]       nb_in,
    input  logic [$clog2(SIDE * SIDE)-1:0]       nc_in,
    kims_out_if.source                           results
);

    localparam int SITES  = SIDE * SIDE;
    localparam int AW     = $clog2(SITES);
    localparam int EW_RAW = $clog2(6 * SITES + 1) + 1;
    localparam int MW_RAW = $clog2(SITES + 1) + 1;
    localparam int EW     = (EW_RAW > kims_pkg::ENERGY_W) ? EW_RAW : kims_pkg::ENERGY_W;
    localparam int MW     = (MW_RAW > kims_pkg::MAG_W) ? MW_RAW : kims_pkg::MAG_W;
    localparam logic [1:0] E_PARITY = 2'((6 * SITES) % 4);

    kims_pkg::back_state_t state_reg, state_next;

    logic [AW-1:0]              clr_reg, clr_next;
    kims_pkg::kims_cmd_t        cmd_reg;
    logic [kims_pkg::RND_W-1:0] rnd_reg;
    logic [AW-1:0]              self_reg;

    logic signed [EW-1:0] energy_reg, energy_after;
    logic signed [MW-1:0] mag_reg [3];
    logic signed [MW-1:0] mag_after [3];

    logic       res_valid_reg, res_valid_next;
    logic       res_flipped_reg, res_done_reg;
    logic signed [kims_pkg::ENERGY_W-1:0] res_energy_reg;
    logic signed [kims_pkg::MAG_W-1:0]    res_mag_reg [3];

    logic          out_free, commit, clear_we;
    logic          flip, own;
    logic signed [5:0] de6;
    logic [AW-1:0] nb_addr [3];
    logic          rd_self [3];
    logic          rd_nb   [3];

    assign nb_addr[0] = na_in;
    assign nb_addr[1] = nb_in;
    assign nb_addr[2] = nc_in;

    // Three spin stores, each read at (x, y) and at one shifted neighbour
    for (genvar k = 0; k < 3; k++)
    begin : g_store
        logic we_k;
        assign we_k = clear_we || (commit && flip && (cmd_reg.sub == 2'(k)));
        kims_ram #(
            .WIDTH (1),
            .DEPTH (SITES)
        ) u_ram (
            .clk     (clk),
            .we      (we_k),
            .waddr   (clear_we ? clr_reg : self_reg),
            .wdata   (clear_we ? 1'b1 : ~own),
            .re      (cmd_pop),
            .raddr_a (self_in),
            .raddr_b (nb_addr[k]),
            .rdata_a (rd_self[k]),
            .rdata_b (rd_nb[k])
        );
    end

    // Count aligned neighbours and decide the flip
    always_comb
    begin : decide
        logic [3:0] nbr;
        logic [2:0] aligned;
        logic       ok4, ok8, accept;
        case (cmd_reg.sub)
            kims_pkg::SUB_ONE:
            begin
                own = rd_self[0];
                nbr = {rd_self[1], rd_nb[1], rd_self[2], rd_nb[2]};
            end
            kims_pkg::SUB_TWO:
            begin
                own = rd_self[1];
                nbr = {rd_self[0], rd_nb[0], rd_self[2], rd_nb[2]};
            end
            kims_pkg::SUB_THREE:
            begin
                own = rd_self[2];
                nbr = {rd_self[0], rd_nb[0], rd_self[1], rd_nb[1]};
            end
            default:
            begin
                own = rd_self[0];
                nbr = '0;
            end
        endcase
        aligned = '0;
        for (int i = 0; i < 4; i++)
        begin
            aligned = aligned + 3'(nbr[i] == own);
        end
        ok4    = {1'b0, rnd_reg} < thr_de4;
        ok8    = {1'b0, rnd_reg} < thr_de8;
        accept = (aligned >= 3'd2) || ((aligned == 3'd1) && ok4) || ((aligned == 3'd0) && ok8);
        flip   = cmd_reg.active && (cmd_reg.trial ? accept : (own != cmd_reg.spin_up));
        de6    = 6'sd8 - $signed({1'b0, aligned, 2'b00});
    end

    // Counter values after the item in flight
    always_comb
    begin
        energy_after = flip ? energy_reg + {{(EW - 6){de6[5]}}, de6} : energy_reg;
        for (int k = 0; k < 3; k++)
        begin
            mag_after[k] = mag_reg[k];
            if (flip && (cmd_reg.sub == 2'(k)))
            begin
                mag_after[k] = own ? mag_reg[k] - MW'(2) : mag_reg[k] + MW'(2);
            end
        end
    end

    assign out_free = !res_valid_reg || results.ready;
    assign clearing = (state_reg == kims_pkg::BK_CLEAR);

    // Sequencer: clear, then alternate issuing reads (when a command waits) and executing (when the output is free)
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        clear_we   = 1'b0;
        cmd_pop    = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            kims_pkg::BK_CLEAR:
            begin
                clear_we = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(SITES - 1))
                begin
                    state_next = kims_pkg::BK_ISSUE;
                end
            end
            kims_pkg::BK_ISSUE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    state_next = kims_pkg::BK_EXEC;
                end
            end
            kims_pkg::BK_EXEC:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = kims_pkg::BK_ISSUE;
                end
            end
            default:
            begin
                state_next = kims_pkg::BK_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kims_pkg::BK_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
            energy_reg    <= EW'(6 * SITES);
            for (int k = 0; k < 3; k++)
            begin
                mag_reg[k] <= MW'(SITES);
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
            if (commit)
            begin
                energy_reg <= energy_after;
                for (int k = 0; k < 3; k++)
                begin
                    mag_reg[k] <= mag_after[k];
                end
            end
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg  <= cmd_in;
            rnd_reg  <= rnd_in;
            self_reg <= self_in;
        end
        if (commit)
        begin
            res_flipped_reg <= flip;
            res_done_reg    <= cmd_reg.sweep_done;
            res_energy_reg  <= energy_after[kims_pkg::ENERGY_W-1:0];
            for (int k = 0; k < 3; k++)
            begin
                res_mag_reg[k] <= mag_after[k][kims_pkg::MAG_W-1:0];
            end
        end
    end

    assign results.valid      = res_valid_reg;
    assign results.flipped    = res_flipped_reg;
    assign results.energy     = res_energy_reg;
    assign results.mag_one    = res_mag_reg[0];
    assign results.mag_two    = res_mag_reg[1];
    assign results.mag_three  = res_mag_reg[2];
    assign results.sweep_done = res_done_reg;

    // Every flip moves the energy by a multiple of four
    a_energy_parity: assert property (@(posedge clk) disable iff (!rst_n)
        energy_reg[1:0] == E_PARITY)
        else $error("energy lost its parity");

    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(energy_reg) && $stable(mag_reg[0])
                    && $stable(mag_reg[1]) && $stable(mag_reg[2]))
        else $error("counters moved without a commit");

    a_pop_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == kims_pkg::BK_EXEC) && !cmd_pop)
        else $error("read issue not followed by execute");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !cmd_pop && !results.valid)
        else $error("item processed during clearing pass");

endmodule

/* hw/rtl/kagome_ising_metropolis_sweep_core.sv */
// Top level of the kagome Ising Metropolis sweep core: APB registers and channel wiring.
//
// Usage:
//   items   : valid/ready input channel. action = 1 runs a Metropolis trial at
//             the next site of the sweep (sublattice one, two, three, each in
//             raster order); action = 0 writes spin_up into one site.
//   results : valid/ready output channel, one result item per input item:
//             flipped, running energy, three sublattice magnetizations and
//             sweep_done on the last site of a sweep.
//   APB     : accept_de4 at byte address 0, accept_de8 at byte address 8
//             (33-bit thresholds, 2^32 = always accept). Write only while idle.
// Path: an accepted item enters the queue, the back end pops it while reading the
//   spin stores, and its result is registered when the flipped spin is written.
//   The back end finishes one item (issue state, then execute state) before it pops
//   the next. A two-entry queue lets the front take items while the back is busy.
// Reset: spins all +1, energy 6*SIDE*SIDE, magnetizations SIDE*SIDE, sweep
//   pointer at the origin. A clearing pass then writes +1 to all SIDE*SIDE sites (256 at
//   the default size) of each store; items are held off until it ends.
// Stall: a result waits in the output register while results.ready is low;
//   items keep entering the queue until it fills, then items.ready drops.
module kagome_ising_metropolis_sweep_core #(
    parameter int SIDE = kims_pkg::SIDE_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kims_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [kims_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [kims_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    kims_in_if.sink                             items,
    kims_out_if.source                          results
);

    localparam int AW    = $clog2(SIDE * SIDE);
    localparam int CMD_W = $bits(kims_pkg::kims_cmd_t) + kims_pkg::RND_W + 4 * AW;

    logic [kims_pkg::THRESH_W-1:0] thr_de4_reg, thr_de8_reg;
    logic                          cfg_write;

    // Front-to-queue and queue-to-back signals
    logic                       push_valid, push_ready;
    kims_pkg::kims_cmd_t        push_cmd, pop_cmd;
    logic [kims_pkg::RND_W-1:0] push_rnd, pop_rnd;
    logic [AW-1:0]              push_self, push_na, push_nb, push_nc;
    logic [AW-1:0]              pop_self, pop_na, pop_nb, pop_nc;
    logic                       pop_valid, pop;
    logic [CMD_W-1:0]           pop_data;
    logic                       clearing;

    // Configuration registers: write in the access phase, always ready
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_de4_reg <= kims_pkg::THRESH_RESET;
            thr_de8_reg <= kims_pkg::THRESH_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == kims_pkg::REG_ACCEPT_DE4)
            begin
                thr_de4_reg <= pwdata[kims_pkg::THRESH_W-1:0];
            end
            else
            begin
                thr_de8_reg <= pwdata[kims_pkg::THRESH_W-1:0];
            end
        end
    end

    assign prdata = {{(kims_pkg::APB_DATA_W - kims_pkg::THRESH_W){1'b0}},
                     (paddr[3] == kims_pkg::REG_ACCEPT_DE8) ? thr_de8_reg : thr_de4_reg};

    // Front: accept and classify items, form store addresses
    kims_front #(
        .SIDE (SIDE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .clearing   (clearing),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_rnd   (push_rnd),
        .push_self  (push_self),
        .push_na    (push_na),
        .push_nb    (push_nb),
        .push_nc    (push_nc)
    );

    // Queue decoupling front and back
    kims_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (kims_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_cmd, push_rnd, push_self, push_na, push_nb, push_nc}),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    assign {pop_cmd, pop_rnd, pop_self, pop_na, pop_nb, pop_nc} = pop_data;

    // Back: spin stores, Metropolis decision, counters and result register
    kims_back #(
        .SIDE (SIDE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .thr_de4   (thr_de4_reg),
        .thr_de8   (thr_de8_reg),
        .clearing  (clearing),
        .cmd_valid (pop_valid),
        .cmd_pop   (pop),
        .cmd_in    (pop_cmd),
        .rnd_in    (pop_rnd),
        .self_in   (pop_self),
        .na_in     (pop_na),
        .nb_in     (pop_nb),
        .nc_in     (pop_nc),
        .results   (results)
    );

endmodule
